// ----- rtl/icfrp_pkg.sv -----
// ----------------------------------------------------------------------------
// icfrp_pkg: shared types and constants
// Register indexes, sequencer states and fixed widths for the chunk framer.
// ----------------------------------------------------------------------------
package icfrp_pkg;

  localparam int unsigned TimeW = 48;
  localparam int unsigned SizeW = 33;
  localparam int unsigned CfgW  = 32;

  localparam logic [1:0] RegNumStreams = 2'd0;
  localparam logic [1:0] RegMinBytes   = 2'd1;
  localparam logic [1:0] RegWindowMs   = 2'd2;
  localparam logic [1:0] RegStampMs    = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REC,
    ST_READ,
    ST_SUM,
    ST_PAD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic         we;
    logic [TimeW-1:0] wtime;
    logic [SizeW-1:0] wsize;
  } hist_wr_t;

  function automatic logic [1:0] size_code(input logic [SizeW-1:0] n);
    logic [1:0] c;
    if (n[SizeW-1:8] == '0) c = 2'd0;
    else if (n[SizeW-1:16] == '0) c = 2'd1;
    else if (n[SizeW-1] == 1'b0) c = 2'd2;
    else c = 2'd3;
    return c;
  endfunction

endpackage

// ----- rtl/icfrp_ram.sv -----
// ----------------------------------------------------------------------------
// icfrp_ram: generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module icfrp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/interleave_chunk_framer_rate_padder.sv -----
// ----------------------------------------------------------------------------
// interleave_chunk_framer_rate_padder
// Frames chunk headers and sizes rate-window discard padding.
// ----------------------------------------------------------------------------
// channel | ports                               | direction
// input   | in_valid, in_stall, in_* fields     | in
// result  | out_valid, out_stall, out_* fields  | out
// config  | cfg_we, cfg_index, cfg_data         | in
// Steps: rejected items go to ST_OUT at once, control items pass ST_REC,
// stream data passes ST_REC and may walk the history (ST_READ, ST_SUM) and
// pad (ST_PAD). The history RAM read port sets the pace of the walk.
// Reset: synchronous, active low; no clearing pass, a fill count guards reads.
// Result waits in the output register while out_stall is high; no new
// transaction is taken until it leaves.
// ----------------------------------------------------------------------------
module interleave_chunk_framer_rate_padder
  import icfrp_pkg::*;
#(
  parameter int unsigned MAX_STREAMS   = 31,
  parameter int unsigned HISTORY_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_action,
  input  logic [47:0]        in_now_us,
  input  logic [63:0]        in_utc_us,
  input  logic [4:0]         in_stream_index,
  input  logic [31:0]        in_payload_length,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_content_id,
  output logic [3:0]         out_length_bytes,
  output logic [32:0]        out_chunk_data_length,
  output logic               out_stamped,
  output logic [63:0]        out_stamp_us,
  output logic [32:0]        out_chunk_size,
  output logic [31:0]        out_padding_needed,
  output logic [32:0]        out_padding_random_bytes,
  output logic [32:0]        out_padding_size,
  output logic [4:0]         out_streams_left,
  output logic               out_ended,
  output logic               out_bad_request
);

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(HISTORY_DEPTH);
  localparam logic [AW-1:0] LastA  = AW'(HISTORY_DEPTH - 1);

  state_t state_r, state_nxt;

  logic [31:0] min_bytes_r, window_ms_r, stamp_ms_r;
  logic [4:0]  remaining_r;
  logic [AW-1:0] head_r;
  logic [CW-1:0] count_r;
  logic [47:0] first_time_r, last_stamp_r;
  logic        first_valid_r;

  logic        act_r;
  logic [47:0] now_r;
  logic [47:0] win_r;
  logic [32:0] sum_r;
  logic [CW-1:0] walk_r;
  logic [AW-1:0] rptr_r;

  logic [7:0]  cid_r;
  logic [3:0]  lb_r;
  logic [32:0] dlen_r, size_r, rnd_r, psize_r;
  logic [31:0] need_r;
  logic        stamped_r, bad_r;
  logic [63:0] stamp_us_r;

  hist_wr_t    hw;
  logic [47:0] rd_time;
  logic [32:0] rd_size;

  icfrp_ram #(.WIDTH(TimeW), .DEPTH(HISTORY_DEPTH)) u_time (
    .clk(clk), .we(hw.we), .waddr(head_r), .wdata(hw.wtime),
    .raddr(rptr_r), .rdata(rd_time)
  );
  icfrp_ram #(.WIDTH(SizeW), .DEPTH(HISTORY_DEPTH)) u_size (
    .clk(clk), .we(hw.we), .waddr(head_r), .wdata(hw.wsize),
    .raddr(rptr_r), .rdata(rd_size)
  );

  logic in_acc;
  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

  // framing of the accepted transaction
  logic        bad_c, stamp_c;
  logic [32:0] dlen_c;
  logic [1:0]  code_c;
  logic [3:0]  lb_c;
  logic [4:0]  rem_after;
  logic [47:0] dt_c;
  always_comb begin
    bad_c = (remaining_r == '0) ||
            (!in_action && ({27'd0, in_stream_index} >= 32'(MAX_STREAMS)));
    dt_c = in_now_us - last_stamp_r;
    stamp_c = !in_action && (stamp_ms_r != '1) && (in_now_us >= last_stamp_r) &&
              ({16'd0, dt_c} >= 64'(stamp_ms_r) * 64'd1000);
    dlen_c = in_action ? ({1'b0, in_payload_length} + 33'd1) : {1'b0, in_payload_length};
    code_c = size_code(dlen_c);
    lb_c   = 4'd1 << code_c;
    rem_after = (!in_action && in_payload_length == '0) ? remaining_r - 5'd1 : remaining_r;
  end

  // padding computation
  logic [32:0] need_c, rnd_c, pdl_c;
  assign need_c = {1'b0, min_bytes_r} - sum_r;
  assign rnd_c  = (need_c + 33'd3) & ~33'd3;
  assign pdl_c  = rnd_c + 33'd1;

  // the very first chunk is recorded in ST_REC, so it is its own first time
  logic [47:0] first_eff_c;
  assign first_eff_c = first_valid_r ? first_time_r : now_r;

  logic hit_c, older_c;
  assign older_c = (49'(rd_time) + 49'(win_r)) < 49'(now_r);
  assign hit_c   = ({1'b0, sum_r} + {1'b0, rd_size}) >= {2'b00, min_bytes_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = (bad_c) ? ST_OUT : ST_REC;
      ST_REC: begin
        if (!act_r && remaining_r != '0 && min_bytes_r != '0 &&
            !(49'(first_eff_c) + 49'(win_r) > 49'(now_r))) begin
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_READ: state_nxt = (walk_r == count_r) ? ST_PAD : ST_SUM;
      ST_SUM: begin
        if (older_c) state_nxt = ST_PAD;
        else if (hit_c) state_nxt = ST_OUT;
        else state_nxt = ST_READ;
      end
      ST_PAD: state_nxt = ST_OUT;
      ST_OUT: if (!out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    hw.we = 1'b0;
    hw.wtime = now_r;
    hw.wsize = size_r;
    case (state_r)
      ST_REC: hw.we = 1'b1;
      ST_PAD: begin
        hw.we = 1'b1;
        hw.wsize = 33'd1 + 33'(4'd1 << size_code(pdl_c)) + pdl_c;
      end
      default: hw.we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      min_bytes_r <= '0;
      window_ms_r <= '0;
      stamp_ms_r <= '1;
      remaining_r <= 5'd1;
      head_r <= '0;
      count_r <= '0;
      first_time_r <= '0;
      first_valid_r <= 1'b0;
      last_stamp_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          RegNumStreams: remaining_r <= cfg_data[4:0];
          RegMinBytes: min_bytes_r <= cfg_data;
          RegWindowMs: window_ms_r <= cfg_data;
          RegStampMs:  stamp_ms_r <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == ST_IDLE && in_acc && !bad_c) begin
        remaining_r <= rem_after;
        if (stamp_c) last_stamp_r <= in_now_us;
      end
      if (hw.we) begin
        head_r <= (head_r == LastA) ? '0 : head_r + AW'(1);
        if (count_r != DepthC) count_r <= count_r + CW'(1);
        if (!first_valid_r) begin
          first_valid_r <= 1'b1;
          first_time_r <= now_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: if (in_acc) begin
        act_r <= in_action;
        now_r <= in_now_us;
        win_r <= 48'(window_ms_r) * 48'd1000;
        bad_r <= bad_c;
        stamped_r <= stamp_c && !bad_c;
        stamp_us_r <= (stamp_c && !bad_c) ? in_utc_us : '0;
        cid_r <= bad_c ? 8'd0 : in_action ? {code_c, 1'b0, 5'(MAX_STREAMS)}
                                          : {code_c, stamp_c, in_stream_index};
        lb_r <= bad_c ? 4'd0 : lb_c;
        dlen_r <= bad_c ? 33'd0 : dlen_c;
        size_r <= 33'd1 + 33'(lb_c) + (stamp_c ? 33'd8 : 33'd0) + dlen_c;
        need_r <= '0;
        rnd_r <= '0;
        psize_r <= '0;
        sum_r <= '0;
        walk_r <= '0;
      end
      ST_REC: begin
        if (bad_r) size_r <= '0;
        rptr_r <= head_r;
      end
      ST_READ: rptr_r <= (rptr_r == '0) ? LastA : rptr_r - AW'(1);
      ST_SUM: begin
        if (!older_c) begin
          sum_r <= sum_r + rd_size;
          walk_r <= walk_r + CW'(1);
        end
      end
      ST_PAD: begin
        need_r <= need_c[31:0];
        rnd_r <= rnd_c;
        psize_r <= hw.wsize;
      end
      default: ;
    endcase
  end

  // rejected items skip ST_REC, so the chunk size is masked at the output instead
  logic bad_pass;
  assign bad_pass = bad_r;

  assign out_content_id = cid_r;
  assign out_length_bytes = lb_r;
  assign out_chunk_data_length = dlen_r;
  assign out_stamped = stamped_r;
  assign out_stamp_us = stamp_us_r;
  assign out_chunk_size = bad_pass ? 33'd0 : size_r;
  assign out_padding_needed = need_r;
  assign out_padding_random_bytes = rnd_r;
  assign out_padding_size = psize_r;
  assign out_streams_left = remaining_r;
  assign out_ended = (remaining_r == '0);
  assign out_bad_request = bad_r;

endmodule

// ----- rtl/icfrp_checker.sv -----
// ----------------------------------------------------------------------------
// icfrp_checker: port-level checks for the chunk framer
// Watches handshakes and result consistency on the top-level ports.
// ----------------------------------------------------------------------------
module icfrp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [4:0]  out_streams_left,
  input logic        out_ended,
  input logic        out_bad_request,
  input logic [32:0] out_chunk_size,
  input logic [32:0] out_padding_size
);

  a_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input open during result");

  a_ended: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_ended == (out_streams_left == 5'd0))) else $error("ended mismatch");

  a_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_request |-> out_chunk_size == 33'd0 && out_padding_size == 33'd0)
    else $error("rejected transaction has size");

endmodule

bind interleave_chunk_framer_rate_padder icfrp_checker u_icfrp_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_streams_left(out_streams_left),
  .out_ended(out_ended), .out_bad_request(out_bad_request),
  .out_chunk_size(out_chunk_size), .out_padding_size(out_padding_size)
);

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: chunk framer and rate padder testbench
// Drives stream-data and control chunks through the valid/stall channels and
// compares every header and padding result with an in-bench framing model.
// A directed table covers field extremes, rejects, timestamps and padding;
// random phases then sweep register settings with random idling and stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import icfrp_pkg::*;

  localparam int MaxStreams = 31;
  localparam int HistDepth  = 64;
  localparam logic [31:0] AllOnes = 32'hFFFF_FFFF;

  typedef struct {
    logic [7:0]  cid;
    logic [3:0]  lb;
    logic [32:0] dlen;
    logic        st;
    logic [63:0] stamp;
    logic [32:0] size;
    logic [31:0] need;
    logic [32:0] rnd;
    logic [32:0] psize;
    logic [4:0]  left;
    logic        ended;
    logic        bad;
  } chunk_res_t;

  typedef struct {
    chunk_res_t  res;
    logic        typed;
    logic [7:0]  t_cid;
    logic [32:0] t_size;
    logic        t_bad;
  } chunk_exp_t;

  typedef struct {
    logic        is_cfg;
    logic [1:0]  reg_idx;
    logic [31:0] reg_val;
    logic        action;
    logic [47:0] now;
    logic [4:0]  idx;
    logic [31:0] plen;
    logic        typed;
    logic [7:0]  t_cid;
    logic [32:0] t_size;
    logic        t_bad;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_action = 1'b0;
  logic [47:0] in_now_us = '0;
  logic [63:0] in_utc_us = '0;
  logic [4:0]  in_stream_index = '0;
  logic [31:0] in_payload_length = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_content_id;
  logic [3:0]  out_length_bytes;
  logic [32:0] out_chunk_data_length;
  logic        out_stamped;
  logic [63:0] out_stamp_us;
  logic [32:0] out_chunk_size;
  logic [31:0] out_padding_needed;
  logic [32:0] out_padding_random_bytes;
  logic [32:0] out_padding_size;
  logic [4:0]  out_streams_left;
  logic        out_ended;
  logic        out_bad_request;

  logic        cur_typed = 1'b0;
  logic [7:0]  cur_cid = '0;
  logic [32:0] cur_size = '0;
  logic        cur_bad = 1'b0;

  // framing model state
  logic [47:0] hist_time [HistDepth];
  logic [32:0] hist_size [HistDepth];
  int          hist_head = 0;
  int          hist_count = 0;
  logic [47:0] first_time = '0;
  logic        first_valid = 1'b0;
  logic [47:0] last_stamp = '0;
  logic [4:0]  remaining = 5'd1;
  logic [4:0]  num_streams = 5'd1;
  logic [31:0] min_bytes = '0;
  logic [31:0] window_ms = '0;
  logic [31:0] stamp_ms = AllOnes;

  chunk_exp_t  pending_chunks [$];
  int          errors = 0;
  int          results_seen = 0;

  interleave_chunk_framer_rate_padder i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [1:0] len_code(logic [63:0] n);
    if (n < 64'd256) return 2'd0;
    if (n < 64'd65536) return 2'd1;
    if (n < 64'h1_0000_0000) return 2'd2;
    return 2'd3;
  endfunction

  function automatic void log_chunk(logic [47:0] t, logic [63:0] sz);
    hist_time[hist_head] = t;
    hist_size[hist_head] = sz[32:0];
    hist_head = (hist_head + 1) % HistDepth;
    if (hist_count < HistDepth) hist_count++;
    if (!first_valid) begin
      first_valid = 1'b1;
      first_time = t;
    end
  endfunction

  function automatic logic [63:0] window_shortfall(logic [47:0] now);
    logic [63:0] w;
    logic [63:0] sum;
    int k;
    w = 64'(window_ms) * 64'd1000;
    sum = '0;
    if (min_bytes == 0 || !first_valid) return '0;
    if (64'(first_time) + w > 64'(now)) return '0;
    for (int i = 0; i < hist_count; i++) begin
      k = (hist_head + HistDepth - 1 - i) % HistDepth;
      if (64'(hist_time[k]) + w < 64'(now)) break;
      sum += 64'(hist_size[k]);
      if (sum >= 64'(min_bytes)) return '0;
    end
    return 64'(min_bytes) - sum;
  endfunction

  function automatic chunk_res_t frame_chunk(logic action, logic [47:0] now,
                                             logic [63:0] utc, logic [4:0] idx,
                                             logic [31:0] plen);
    chunk_res_t r;
    logic [63:0] dlen, size, need, rnd, pdl, psize;
    logic [1:0] code;
    logic stamp;
    r = '{default: '0};
    stamp = 1'b0;
    need = '0;
    rnd = '0;
    psize = '0;
    if (remaining == 0 || (!action && idx >= MaxStreams)) begin
      r.left = remaining;
      r.ended = (remaining == 0);
      r.bad = 1'b1;
      return r;
    end
    if (!action) begin
      if (plen == 0) remaining--;
      if (stamp_ms != AllOnes && now >= last_stamp &&
          64'(now - last_stamp) >= 64'(stamp_ms) * 64'd1000) begin
        last_stamp = now;
        stamp = 1'b1;
        r.stamp = utc;
      end
      dlen = 64'(plen);
      code = len_code(dlen);
      r.cid = {code, stamp, idx};
    end else begin
      dlen = 64'(plen) + 64'd1;
      code = len_code(dlen);
      r.cid = {code, 1'b0, 5'(MaxStreams)};
    end
    r.lb = 4'd1 << code;
    size = 64'd1 + 64'(r.lb) + (stamp ? 64'd8 : 64'd0) + dlen;
    log_chunk(now, size);
    if (!action && remaining != 0) begin
      need = window_shortfall(now);
      if (need != 0) begin
        rnd = ((need + 64'd3) / 64'd4) * 64'd4;
        pdl = rnd + 64'd1;
        psize = 64'd1 + (64'd1 << len_code(pdl)) + pdl;
        log_chunk(now, psize);
      end
    end
    r.dlen = dlen[32:0];
    r.st = stamp;
    r.size = size[32:0];
    r.need = need[31:0];
    r.rnd = rnd[32:0];
    r.psize = psize[32:0];
    r.left = remaining;
    r.ended = (remaining == 0);
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $error("%s: expected %0h, got %0h", name, e, a);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    chunk_exp_t x;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          RegNumStreams: begin
            num_streams = cfg_data[4:0];
            remaining = cfg_data[4:0];
          end
          RegMinBytes: min_bytes = cfg_data;
          RegWindowMs: window_ms = cfg_data;
          RegStampMs:  stamp_ms = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        x.res = frame_chunk(in_action, in_now_us, in_utc_us, in_stream_index,
                            in_payload_length);
        x.typed = cur_typed;
        x.t_cid = cur_cid;
        x.t_size = cur_size;
        x.t_bad = cur_bad;
        pending_chunks.push_back(x);
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_chunks.size() == 0) begin
          $error("result transaction with no chunk pending");
          errors++;
        end else begin
          x = pending_chunks.pop_front();
          check_field("content_id", x.res.cid, out_content_id);
          check_field("length_bytes", x.res.lb, out_length_bytes);
          check_field("chunk_data_length", x.res.dlen, out_chunk_data_length);
          check_field("stamped", x.res.st, out_stamped);
          check_field("stamp_us", x.res.stamp, out_stamp_us);
          check_field("chunk_size", x.res.size, out_chunk_size);
          check_field("padding_needed", x.res.need, out_padding_needed);
          check_field("padding_random_bytes", x.res.rnd, out_padding_random_bytes);
          check_field("padding_size", x.res.psize, out_padding_size);
          check_field("streams_left", x.res.left, out_streams_left);
          check_field("ended", x.res.ended, out_ended);
          check_field("bad_request", x.res.bad, out_bad_request);
          if (x.typed) begin
            check_field("content_id", x.t_cid, out_content_id);
            check_field("chunk_size", x.t_size, out_chunk_size);
            check_field("bad_request", x.t_bad, out_bad_request);
          end
        end
      end
    end
  end

  // receiver: random stall, one long hold-off once traffic is flowing
  initial begin
    int sel;
    bit held;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!held && results_seen > 300) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (600) @(posedge clk);
      end
      sel = $urandom_range(0, 9);
      if (sel < 5) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else if (sel < 9) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end
    end
  end

  bit no_gaps = 1'b0;

  task automatic send_chunk(logic action, logic [47:0] now, logic [63:0] utc,
                            logic [4:0] idx, logic [31:0] plen);
    int gap;
    gap = 0;
    if (!no_gaps && $urandom_range(0, 9) >= 6)
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= action;
    in_now_us <= now;
    in_utc_us <= utc;
    in_stream_index <= idx;
    in_payload_length <= plen;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_chunks.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_regs(logic [31:0] ns, logic [31:0] mb, logic [31:0] wm,
                            logic [31:0] sm);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= RegNumStreams;
    cfg_data <= ns;
    @(posedge clk);
    cfg_index <= RegMinBytes;
    cfg_data <= mb;
    @(posedge clk);
    cfg_index <= RegWindowMs;
    cfg_data <= wm;
    @(posedge clk);
    cfg_index <= RegStampMs;
    cfg_data <= sm;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  dir_row_t dir_rows [] = '{
    '{0, RegNumStreams, 0, 0, 48'd1000, 5'd0, 32'd0, 1, 8'h00, 33'd2, 0},
    '{0, RegNumStreams, 0, 1, 48'd1100, 5'd0, 32'd4, 1, 8'h00, 33'd0, 1},
    '{1, RegNumStreams, 32'd31, 0, 0, 0, 0, 0, 0, 0, 0},
    '{1, RegStampMs, 32'd0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, RegNumStreams, 0, 0, 48'd2000, 5'd30, AllOnes, 1, 8'hBE, 33'h1_0000_000C, 0},
    '{0, RegNumStreams, 0, 1, 48'd2000, 5'd7, AllOnes, 1, 8'hDF, 33'h1_0000_0009, 0},
    '{0, RegNumStreams, 0, 0, 48'd2000, 5'd31, 32'd9, 1, 8'h00, 33'd0, 1},
    '{0, RegNumStreams, 0, 0, 48'd2000, 5'd0, 32'd255, 1, 8'h20, 33'd265, 0},
    '{0, RegNumStreams, 0, 0, 48'd2000, 5'd1, 32'd256, 1, 8'h61, 33'd267, 0},
    '{0, RegNumStreams, 0, 0, 48'd2000, 5'd2, 32'd65536, 1, 8'hA2, 33'd65549, 0},
    '{0, RegNumStreams, 0, 0, 48'd500, 5'd3, 32'd10, 1, 8'h03, 33'd12, 0},
    '{1, RegStampMs, AllOnes, 0, 0, 0, 0, 0, 0, 0, 0},
    '{1, RegMinBytes, AllOnes, 0, 0, 0, 0, 0, 0, 0, 0},
    '{1, RegWindowMs, AllOnes, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, RegNumStreams, 0, 0, 48'd3000, 5'd4, 32'd5, 1, 8'h04, 33'd7, 0},
    '{1, RegWindowMs, 32'd0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{1, RegMinBytes, 32'd1000, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, RegNumStreams, 0, 0, 48'd10000, 5'd5, 32'd10, 0, 0, 0, 0},
    '{0, RegNumStreams, 0, 1, 48'd10100, 5'd0, 32'd0, 0, 0, 0, 0},
    '{0, RegNumStreams, 0, 0, 48'd10200, 5'd6, 32'd0, 0, 0, 0, 0},
    '{0, RegNumStreams, 0, 0, 48'hFFFF_FFFF_FFFF, 5'd6, 32'd3, 0, 0, 0, 0},
    '{1, RegNumStreams, 32'd0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, RegNumStreams, 0, 0, 48'd20000, 5'd1, 32'd8, 1, 8'h00, 33'd0, 1}
  };

  initial begin
    logic [47:0] now;
    logic [31:0] plen;
    logic [4:0] idx;
    int sel;
    int n_items;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].is_cfg) begin
        drain();
        cfg_we <= 1'b1;
        cfg_index <= dir_rows[r].reg_idx;
        cfg_data <= dir_rows[r].reg_val;
        @(posedge clk);
        cfg_we <= 1'b0;
      end else begin
        cur_typed <= dir_rows[r].typed;
        cur_cid <= dir_rows[r].t_cid;
        cur_size <= dir_rows[r].t_size;
        cur_bad <= dir_rows[r].t_bad;
        send_chunk(dir_rows[r].action, dir_rows[r].now, {$urandom, $urandom},
                   dir_rows[r].idx, dir_rows[r].plen);
      end
    end
    cur_typed <= 1'b0;

    for (int ph = 0; ph < 8; ph++) begin
      now = 48'd1000;
      n_items = 240;
      no_gaps = (ph == 3);
      case (ph)
        0: write_regs(31, $urandom_range(0, 3000), $urandom_range(1, 3),
                      $urandom_range(0, 3));
        1: begin
          write_regs(31, AllOnes, AllOnes, AllOnes);
          now = 48'hFFF0_0000_0000;
        end
        2: begin
          write_regs(0, $urandom_range(0, 3000), 1, 0);
          n_items = 20;
        end
        3: write_regs(31, AllOnes, 0, 0);
        4: begin
          write_regs($urandom, $urandom, $urandom, $urandom);
          now = {$urandom, $urandom};
        end
        default: write_regs($urandom_range(1, 31), $urandom_range(0, 4000),
                            $urandom_range(0, 8),
                            ($urandom_range(0, 3) == 0) ? AllOnes : $urandom_range(0, 4));
      endcase
      for (int n = 0; n < n_items; n++) begin
        sel = $urandom_range(0, 99);
        if (sel == 0) now = {$urandom, $urandom};
        else if (sel < 8) now = now - 48'($urandom_range(0, 500));
        else now = now + 48'($urandom_range(0, 1500));
        idx = ($urandom_range(0, 15) == 0) ? 5'd31 : 5'($urandom_range(0, 30));
        sel = $urandom_range(0, 39);
        if (sel == 0) plen = 32'd0;
        else if (sel < 3) plen = $urandom;
        else if (sel < 7) plen = $urandom_range(256, 70000);
        else plen = $urandom_range(1, 400);
        send_chunk($urandom_range(0, 7) == 0, now, {$urandom, $urandom}, idx, plen);
      end
    end
    no_gaps = 1'b0;

    drain();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/icfrp_pkg.sv
rtl/icfrp_ram.sv
rtl/interleave_chunk_framer_rate_padder.sv
rtl/icfrp_checker.sv
bench/tb_top.sv
